[rtl/ppe_pkg.sv]
// Shared types, constants and helper functions of the particle pool engine.
package ppe_pkg;

  localparam int POOL_SLOTS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam int CW          = 36;   // CORDIC x/y width
  localparam int ZW          = 33;   // CORDIC angle width, Q28
  localparam int TW          = 6;    // tally width
  localparam int QDEPTH      = 2;    // command queue depth
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 200;

  localparam logic signed [ZW-1:0] HALF_PI_Q28  = 33'sd421657428;
  localparam logic [29:0]          GAIN_INV_Q30 = 30'd652032874;
  localparam logic [15:0]          LFSR_MASK    = 16'hB400;
  localparam logic [15:0]          SEED_RESET   = 16'd44257;

  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRAVITY_X   = 3'd0,
    CFG_GRAVITY_Y   = 3'd1,
    CFG_ORIGIN_X    = 3'd2,
    CFG_ORIGIN_Y    = 3'd3,
    CFG_RANDOM_SEED = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    B_IDLE, B_E_FIND, B_E_ANG, B_E_DIR, B_V_RUN, B_V_LO, B_V_HI, B_E_RAD,
    B_R_RUN, B_UX_LO, B_UX_HI, B_UY_LO, B_UY_HI, B_E_WR, B_E_ACK,
    B_T_GMUL, B_T_SCAN, B_T_RD, B_T_MUL, B_T_POS, B_T_SUM
  } back_state_t;

  typedef struct packed {
    logic               is_tick;
    logic [5:0]         count;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [18:0]        spread;
    logic [31:0]        tint;
    logic [23:0]        size;
    logic [30:0]        life;
    logic               radial;
    logic [15:0]        dt;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] life;
    logic [30:0]        life_init;
    logic [31:0]        tint;
    logic [23:0]        size;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [4:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] life_left;
    logic [30:0]        life_start;
    logic [31:0]        tint;
    logic [23:0]        size;
    logic [TW-1:0]      tally;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               load;
    logic               vec;    // 1 vectoring, 0 rotation
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_req_t;

  function automatic logic [27:0] atan_q28(input logic [4:0] i);
    logic [27:0] a;
    unique case (i)
      5'd0:  a = 28'd210828714;
      5'd1:  a = 28'd124459457;
      5'd2:  a = 28'd65760959;
      5'd3:  a = 28'd33381290;
      5'd4:  a = 28'd16755422;
      5'd5:  a = 28'd8385879;
      5'd6:  a = 28'd4193963;
      5'd7:  a = 28'd2097109;
      5'd8:  a = 28'd1048571;
      5'd9:  a = 28'd524287;
      5'd10: a = 28'd262144;
      5'd11: a = 28'd131072;
      5'd12: a = 28'd65536;
      5'd13: a = 28'd32768;
      5'd14: a = 28'd16384;
      5'd15: a = 28'd8192;
      5'd16: a = 28'd4096;
      5'd17: a = 28'd2048;
      5'd18: a = 28'd1024;
      5'd19: a = 28'd512;
      5'd20: a = 28'd256;
      5'd21: a = 28'd128;
      5'd22: a = 28'd64;
      5'd23: a = 28'd32;
      default: a = 28'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] lfsr_next(input logic [15:0] l);
    logic [15:0] n;
    n = {1'b0, l[15:1]};
    if (l[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

endpackage

[rtl/ppe_front.sv]
// Front end: input transfer, command decode and the short command queue.
module ppe_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppe_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  output logic                           q_valid,
  output ppe_pkg::cmd_t                  q_head,
  input  logic                           q_pop
);
  import ppe_pkg::*;

  cmd_t       q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       push, pop;

  // decode: tick items only carry delta time, emit items the rest
  always_comb begin
    cmd_in         = '0;
    cmd_in.is_tick = (in_tuser == FUNC_TICK);
    cmd_in.count   = in_tdata[5:0];
    cmd_in.dx      = $signed(in_tdata[37:6]);
    cmd_in.dy      = $signed(in_tdata[69:38]);
    cmd_in.spread  = in_tdata[88:70];
    cmd_in.tint    = in_tdata[120:89];
    cmd_in.size    = in_tdata[144:121];
    cmd_in.life    = in_tdata[175:145];
    cmd_in.radial  = in_tdata[176];
    cmd_in.dt      = in_tdata[192:177];
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_head    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

[rtl/ppe_cordic.sv]
// Iterative CORDIC: one micro-rotation per cycle, rotation or vectoring.
module ppe_cordic #(
  parameter int CORDIC_STEPS = ppe_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppe_pkg::cord_req_t            req,
  output logic                          busy,
  output logic signed [ppe_pkg::CW-1:0] x_out,
  output logic signed [ppe_pkg::CW-1:0] y_out
);
  import ppe_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt, at;
  logic [4:0]           i_r, i_nxt;
  logic                 vec_r, vec_nxt, busy_r, busy_nxt, neg;

  always_comb begin
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    at  = $signed({5'b0, atan_q28(i_r)});
    neg = vec_r ? !y_r[CW-1] : z_r[ZW-1];
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    vec_nxt = vec_r; busy_nxt = busy_r;
    if (req.load) begin
      x_nxt = req.x; y_nxt = req.y; z_nxt = req.z;
      vec_nxt = req.vec; i_nxt = 5'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (neg) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    vec_r <= vec_nxt;
  end

  assign busy  = busy_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

[rtl/ppe_back.sv]
// Back end: slot pool, emit and tick sequencer, result register.
module ppe_back #(
  parameter int POOL_SLOTS = ppe_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ppe_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  input  logic signed [31:0]            gravity_x,
  input  logic signed [31:0]            gravity_y,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic                          lfsr_load,
  input  logic [15:0]                   lfsr_seed,
  output ppe_pkg::cord_req_t            cord_req,
  input  logic                          cord_busy,
  input  logic signed [ppe_pkg::CW-1:0] cord_x,
  input  logic signed [ppe_pkg::CW-1:0] cord_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ppe_pkg::res_t                 out_pkt
);
  import ppe_pkg::*;

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int IW = $clog2(POOL_SLOTS + 1);

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [5:0]           c_r, c_nxt;
  logic [TW-1:0]        emitted_r, emitted_nxt, alive_r, alive_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [15:0]          r_r, r_nxt, lfsr_r, lfsr_nxt;
  logic signed [35:0]   prod_r, prod_nxt;
  logic signed [CW-1:0] speed_r, speed_nxt;
  logic [47:0]          ug_p_r, ug_p_nxt;
  logic signed [31:0]   vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [31:0]   gdx_r, gdx_nxt, gdy_r, gdy_nxt;
  logic signed [31:0]   mx_r, mx_nxt, my_r, my_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [POOL_SLOTS-1:0] active_r, active_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_pkt_r, out_pkt_nxt;

  entry_t               mem [POOL_SLOTS];
  entry_t               rd_q, mem_wdata;
  logic                 mem_we, mem_re;
  logic [SW-1:0]        mem_waddr, mem_raddr;

  logic                 free_found, out_free, survive;
  logic [SW-1:0]        free_idx;
  logic [15:0]          lfsr_step;
  logic signed [15:0]   r_ctr;
  logic signed [ZW-1:0] z_dir;
  logic [42:0]          rz_prod;
  logic signed [CW-1:0] ug_src;
  logic signed [17:0]   ug_h;
  logic signed [48:0]   ug_hi;
  logic [47:0]          ug_lo;
  logic signed [67:0]   ug_sum;
  logic signed [37:0]   ug_res;
  logic signed [48:0]   gmx, gmy, mvx, mvy;
  logic signed [31:0]   life_new;
  logic signed [CW-1:0] dxe, dye;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign lfsr_step = lfsr_next(lfsr_r);
  assign r_ctr     = $signed({~r_r[15], r_r[14:0]});   // r - 0.5
  assign z_dir     = ZW'(prod_r >>> 4);
  assign rz_prod   = 43'(r_r[13:0]) * 43'(HALF_PI_Q28[28:0]);
  assign dxe       = CW'(cmd_r.dx);
  assign dye       = CW'(cmd_r.dy);

  // gain removal, split in a low and a high partial product
  assign ug_src = (state_r == B_UY_LO || state_r == B_UY_HI) ? cord_y : cord_x;
  assign ug_h   = ug_src[CW-1:18];
  assign ug_lo  = 48'(ug_src[17:0]) * 48'(GAIN_INV_Q30);
  assign ug_hi  = ug_h * $signed({1'b0, GAIN_INV_Q30});
  assign ug_sum = (68'(ug_hi) <<< 18) + $signed({20'b0, ug_p_r});
  assign ug_res = 38'(ug_sum >>> 30);

  // Euler products
  assign gmx      = gravity_x * $signed({1'b0, cmd_r.dt});
  assign gmy      = gravity_y * $signed({1'b0, cmd_r.dt});
  assign mvx      = vx_r * $signed({1'b0, cmd_r.dt});
  assign mvy      = vy_r * $signed({1'b0, cmd_r.dt});
  assign life_new = rd_q.life - $signed({16'b0, cmd_r.dt});
  assign survive  = (life_new > 32'sd0);

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; c_nxt = c_r;
    emitted_nxt = emitted_r; alive_nxt = alive_r; slot_nxt = slot_r;
    r_nxt = r_r; lfsr_nxt = lfsr_r; prod_nxt = prod_r; speed_nxt = speed_r;
    ug_p_nxt = ug_p_r; vx_nxt = vx_r; vy_nxt = vy_r;
    gdx_nxt = gdx_r; gdy_nxt = gdy_r; mx_nxt = mx_r; my_nxt = my_r;
    idx_nxt = idx_r; active_nxt = active_r;
    out_valid_nxt = out_valid_r; out_pkt_nxt = out_pkt_r;
    q_pop = 1'b0; cord_req = '0;
    mem_we = 1'b0; mem_waddr = slot_r; mem_wdata = rd_q;
    mem_re = 1'b0; mem_raddr = idx_r[SW-1:0];
    out_free = !out_valid_r || out_ready;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_head;
          c_nxt       = 6'd0;
          emitted_nxt = '0;
          state_nxt   = q_head.is_tick ? B_T_GMUL : B_E_FIND;
        end
      end
      B_E_FIND: begin
        if (c_r == cmd_r.count) begin
          state_nxt = B_E_ACK;
        end else begin
          c_nxt = c_r + 6'd1;
          if (free_found) begin
            slot_nxt = free_idx;
            lfsr_nxt = lfsr_step;
            r_nxt    = lfsr_step;
            if (cmd_r.radial) begin
              cord_req.load = 1'b1;
              cord_req.vec  = 1'b1;
              cord_req.x    = cmd_r.dx[31] ? -dxe : dxe;
              cord_req.y    = dye;
              state_nxt     = B_V_RUN;
            end else begin
              state_nxt = B_E_ANG;
            end
          end
        end
      end
      B_E_ANG: begin
        prod_nxt  = $signed({1'b0, cmd_r.spread}) * r_ctr;
        state_nxt = B_E_DIR;
      end
      B_E_DIR: begin
        cord_req.load = 1'b1;
        if (z_dir > HALF_PI_Q28) begin
          cord_req.x = -dye;
          cord_req.y = dxe;
          cord_req.z = z_dir - HALF_PI_Q28;
        end else if (z_dir < -HALF_PI_Q28) begin
          cord_req.x = dye;
          cord_req.y = -dxe;
          cord_req.z = z_dir + HALF_PI_Q28;
        end else begin
          cord_req.x = dxe;
          cord_req.y = dye;
          cord_req.z = z_dir;
        end
        state_nxt = B_R_RUN;
      end
      B_V_RUN: begin
        if (!cord_busy) begin
          state_nxt = B_V_LO;
        end
      end
      B_V_LO: begin
        ug_p_nxt  = ug_lo;
        state_nxt = B_V_HI;
      end
      B_V_HI: begin
        speed_nxt = ug_res[CW-1:0];
        state_nxt = B_E_RAD;
      end
      B_E_RAD: begin
        // top two bits of r are whole quarter turns
        cord_req.load = 1'b1;
        cord_req.z    = $signed({4'b0, rz_prod[42:14]});
        unique case (r_r[15:14])
          2'd0: begin cord_req.x = speed_r;  cord_req.y = '0;       end
          2'd1: begin cord_req.x = '0;       cord_req.y = speed_r;  end
          2'd2: begin cord_req.x = -speed_r; cord_req.y = '0;       end
          default: begin cord_req.x = '0;    cord_req.y = -speed_r; end
        endcase
        state_nxt = B_R_RUN;
      end
      B_R_RUN: begin
        if (!cord_busy) begin
          state_nxt = B_UX_LO;
        end
      end
      B_UX_LO: begin
        ug_p_nxt  = ug_lo;
        state_nxt = B_UX_HI;
      end
      B_UX_HI: begin
        vx_nxt    = sat32(40'(ug_res));
        state_nxt = B_UY_LO;
      end
      B_UY_LO: begin
        ug_p_nxt  = ug_lo;
        state_nxt = B_UY_HI;
      end
      B_UY_HI: begin
        vy_nxt    = sat32(40'(ug_res));
        state_nxt = B_E_WR;
      end
      B_E_WR: begin
        mem_we              = 1'b1;
        mem_waddr           = slot_r;
        mem_wdata.px        = origin_x;
        mem_wdata.py        = origin_y;
        mem_wdata.vx        = vx_r;
        mem_wdata.vy        = vy_r;
        mem_wdata.life      = $signed({1'b0, cmd_r.life});
        mem_wdata.life_init = cmd_r.life;
        mem_wdata.tint      = cmd_r.tint;
        mem_wdata.size      = cmd_r.size;
        active_nxt[slot_r]  = 1'b1;
        emitted_nxt         = emitted_r + TW'(1);
        state_nxt           = B_E_FIND;
      end
      B_E_ACK: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_pkt_nxt       = '0;
          out_pkt_nxt.kind  = KIND_ACK;
          out_pkt_nxt.tally = emitted_r;
          out_pkt_nxt.last  = 1'b1;
          state_nxt         = B_IDLE;
        end
      end
      B_T_GMUL: begin
        gdx_nxt   = 32'(gmx >>> 16);
        gdy_nxt   = 32'(gmy >>> 16);
        idx_nxt   = '0;
        alive_nxt = '0;
        state_nxt = B_T_SCAN;
      end
      B_T_SCAN: begin
        if (idx_r == IW'(POOL_SLOTS)) begin
          state_nxt = B_T_SUM;
        end else if (active_r[idx_r[SW-1:0]]) begin
          mem_re    = 1'b1;
          state_nxt = B_T_RD;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      B_T_RD: begin
        // velocity first
        vx_nxt    = sat32(40'(rd_q.vx) + 40'(gdx_r));
        vy_nxt    = sat32(40'(rd_q.vy) + 40'(gdy_r));
        state_nxt = B_T_MUL;
      end
      B_T_MUL: begin
        mx_nxt    = 32'(mvx >>> 16);
        my_nxt    = 32'(mvy >>> 16);
        state_nxt = B_T_POS;
      end
      B_T_POS: begin
        if (!survive || out_free) begin
          mem_we         = 1'b1;
          mem_waddr      = idx_r[SW-1:0];
          mem_wdata.px   = sat32(40'(rd_q.px) + 40'(mx_r));
          mem_wdata.py   = sat32(40'(rd_q.py) + 40'(my_r));
          mem_wdata.vx   = vx_r;
          mem_wdata.vy   = vy_r;
          mem_wdata.life = life_new;
          idx_nxt        = idx_r + IW'(1);
          state_nxt      = B_T_SCAN;
          if (survive) begin
            alive_nxt              = alive_r + TW'(1);
            out_valid_nxt          = 1'b1;
            out_pkt_nxt.kind       = KIND_REPORT;
            out_pkt_nxt.slot       = 5'(idx_r[SW-1:0]);
            out_pkt_nxt.x          = mem_wdata.px;
            out_pkt_nxt.y          = mem_wdata.py;
            out_pkt_nxt.life_left  = life_new;
            out_pkt_nxt.life_start = rd_q.life_init;
            out_pkt_nxt.tint       = rd_q.tint;
            out_pkt_nxt.size       = rd_q.size;
            out_pkt_nxt.tally      = '0;
            out_pkt_nxt.last       = 1'b0;
          end else begin
            active_nxt[idx_r[SW-1:0]] = 1'b0;
          end
        end
      end
      B_T_SUM: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_pkt_nxt       = '0;
          out_pkt_nxt.kind  = KIND_SUMMARY;
          out_pkt_nxt.tally = alive_r;
          out_pkt_nxt.last  = 1'b1;
          state_nxt         = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (lfsr_load) begin
      lfsr_nxt = lfsr_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      lfsr_r      <= SEED_RESET;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      lfsr_r      <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    c_r       <= c_nxt;
    emitted_r <= emitted_nxt;
    alive_r   <= alive_nxt;
    slot_r    <= slot_nxt;
    r_r       <= r_nxt;
    prod_r    <= prod_nxt;
    speed_r   <= speed_nxt;
    ug_p_r    <= ug_p_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    gdx_r     <= gdx_nxt;
    gdy_r     <= gdy_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    idx_r     <= idx_nxt;
    out_pkt_r <= out_pkt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pkt   = out_pkt_r;

`ifndef SYNTH
  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_E_WR |-> !active_r[slot_r])
    else $error("emit writes an occupied slot");
  a_tick_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_T_POS && mem_we) |-> active_r[idx_r[SW-1:0]])
    else $error("tick updates an inactive slot");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_E_ACK |-> emitted_r <= cmd_r.count)
    else $error("more particles emitted than requested");
  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cord_req.load |-> !cord_busy)
    else $error("CORDIC restarted while busy");
  a_run_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cord_req.load |=> cord_busy)
    else $error("CORDIC did not start");
`endif

endmodule

[rtl/particle_pool_engine_unit.sv]
// Top level of the particle pool engine: ports, config registers, wiring.
//
//  channel | dir | fields (low bit first)
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tuser: func; tdata: emit_count, dir_x, dir_y, spread,
//          |     |   tint, dot_size, life_span, emit_mode, delta_time
//  out_    | out | tuser: kind; tlast: last; tdata: slot, out_x, out_y,
//          |     |   life_left, life_start, out_tint, out_size, tally
//  cfg_    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// An emit makes one try per requested particle; a try that finds a free slot
// runs the CORDIC in rotation (directional) or in vectoring, then rotation
// (radial). A tick visits every slot and updates each active one by a
// read-modify-write. The CORDIC is iterative, the gain multiply two-part.
// Reset clears active bits, queue, FSM, output valid and config; the LFSR
// loads its default seed; slot memory is not cleared. Items queue two deep;
// a new result waits while the output register holds an untaken transfer.
module particle_pool_engine_unit #(
  parameter int POOL_SLOTS   = ppe_pkg::POOL_SLOTS_DEF,
  parameter int CORDIC_STEPS = ppe_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // emit_count, dir_x, dir_y, spread, tint, dot_size, life_span, emit_mode,
  // delta_time, zero pad
  input  logic [ppe_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot, out_x, out_y, life_left, life_start, out_tint, out_size, tally,
  // zero pad
  output logic [ppe_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import ppe_pkg::*;

  logic signed [31:0]   gravity_x_r, gravity_y_r, origin_x_r, origin_y_r;
  logic                 q_valid, q_pop, lfsr_load, cord_busy;
  cmd_t                 q_head;
  cord_req_t            cord_req;
  logic signed [CW-1:0] cord_x, cord_y;
  res_t                 pkt;

  // config registers; a seed write reloads the LFSR at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_x_r <= '0;
      gravity_y_r <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY_X: gravity_x_r <= $signed(cfg_wdata);
        CFG_GRAVITY_Y: gravity_y_r <= $signed(cfg_wdata);
        CFG_ORIGIN_X:  origin_x_r  <= $signed(cfg_wdata);
        CFG_ORIGIN_Y:  origin_y_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign lfsr_load = cfg_we && (cfg_index == CFG_RANDOM_SEED);

  ppe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  ppe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .busy  (cord_busy),
    .x_out (cord_x),
    .y_out (cord_y)
  );

  ppe_back #(.POOL_SLOTS(POOL_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .gravity_x (gravity_x_r),
    .gravity_y (gravity_y_r),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .lfsr_load (lfsr_load),
    .lfsr_seed (cfg_wdata[15:0]),
    .cord_req  (cord_req),
    .cord_busy (cord_busy),
    .cord_x    (cord_x),
    .cord_y    (cord_y),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pkt   (pkt)
  );

  assign out_tdata = {6'b0, pkt.tally, pkt.size, pkt.tint, pkt.life_start,
                      pkt.life_left, pkt.y, pkt.x, pkt.slot};
  assign out_tuser = pkt.kind;
  assign out_tlast = pkt.last;

endmodule
